/* rtl/mbet_pkg.sv */
`default_nettype none

package mbet_pkg;

    // Iteration limit and fixed-point format of the points.
    localparam int ITER_LIMIT = 256;
    localparam int FRAC_BITS  = 28;

    // Port widths.
    localparam int C_W   = 32;
    localparam int OUT_W = 9;

    // Iteration counter wide enough to hold ITER_LIMIT itself.
    localparam int CNT_W = $clog2(ITER_LIMIT + 1);

    // A component of z that has not escaped is below 2.0, so its magnitude
    // fits in FRAC_BITS + 1 bits. Squares of such values lie below 4.0 and the
    // doubled cross product below 8.0.
    localparam int MAG_W  = FRAC_BITS + 1;
    localparam int PROD_W = 2 * MAG_W;
    localparam int SQ_W   = FRAC_BITS + 2;
    localparam int XP_W   = FRAC_BITS + 3;

    // The sum of squares minus the other square plus c must never wrap.
    localparam int Z_W = ((FRAC_BITS + 4 > C_W) ? FRAC_BITS + 4 : C_W) + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SQUARE
    } mbet_state_t;

    typedef struct packed {
        logic load;    // capture c and clear z
        logic add;     // form the next z from the stored products
        logic square;  // form the squares and the cross product
    } mbet_cmd_t;

    typedef struct packed {
        logic sum_esc; // stored squares add up to 4.0 or more
        logic big;     // a component of the stored z is 2.0 or more
    } mbet_status_t;

endpackage

`default_nettype wire

/* rtl/mbet_datapath.sv */
`default_nettype none

module mbet_datapath (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire  mbet_pkg::mbet_cmd_t     cmd,
    input  wire  [mbet_pkg::C_W-1:0]      c_real,
    input  wire  [mbet_pkg::C_W-1:0]      c_imag,
    output mbet_pkg::mbet_status_t        status
);
    import mbet_pkg::*;

    logic [C_W-1:0]   cr_reg;
    logic [C_W-1:0]   ci_reg;
    logic [SQ_W-1:0]  sqr_reg, sqr_next;
    logic [SQ_W-1:0]  sqi_reg, sqi_next;
    logic [XP_W-1:0]  xp_reg, xp_next;
    logic             xp_neg_reg;
    logic [MAG_W-1:0] mr_reg;
    logic [MAG_W-1:0] mi_reg;
    logic             neg_reg;
    logic             big_reg;

    logic [Z_W-1:0]    zr;
    logic [Z_W-1:0]    zi;
    logic [Z_W-1:0]    xp_signed;
    logic [Z_W-1:0]    zr_mag;
    logic [Z_W-1:0]    zi_mag;
    logic [SQ_W:0]     sq_sum;
    logic [PROD_W-1:0] prod_rr;
    logic [PROD_W-1:0] prod_ii;
    logic [PROD_W-1:0] prod_ri;

    // Next z from the stored products: (sqr - sqi + cr, 2*zr*zi + ci).
    always_comb
    begin
        xp_signed = xp_neg_reg ? (Z_W'(0) - Z_W'(xp_reg)) : Z_W'(xp_reg);
        zr = Z_W'(sqr_reg) - Z_W'(sqi_reg) + {{(Z_W - C_W){cr_reg[C_W-1]}}, cr_reg};
        zi = xp_signed + {{(Z_W - C_W){ci_reg[C_W-1]}}, ci_reg};
        zr_mag = zr[Z_W-1] ? (Z_W'(0) - zr) : zr;
        zi_mag = zi[Z_W-1] ? (Z_W'(0) - zi) : zi;
        sq_sum = (SQ_W + 1)'(sqr_reg) + (SQ_W + 1)'(sqi_reg);
    end

    // Magnitude products, cut down to the fixed-point format by truncation.
    always_comb
    begin
        prod_rr  = PROD_W'(mr_reg) * PROD_W'(mr_reg);
        prod_ii  = PROD_W'(mi_reg) * PROD_W'(mi_reg);
        prod_ri  = PROD_W'(mr_reg) * PROD_W'(mi_reg);
        sqr_next = SQ_W'(prod_rr >> FRAC_BITS);
        sqi_next = SQ_W'(prod_ii >> FRAC_BITS);
        xp_next  = XP_W'(prod_ri >> (FRAC_BITS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_reg <= 1'b0;
        end
        else if (cmd.add)
        begin
            big_reg <= (|zr_mag[Z_W-1:MAG_W]) || (|zi_mag[Z_W-1:MAG_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg     <= c_real;
            ci_reg     <= c_imag;
            sqr_reg    <= '0;
            sqi_reg    <= '0;
            xp_reg     <= '0;
            xp_neg_reg <= 1'b0;
        end
        else if (cmd.square)
        begin
            sqr_reg    <= sqr_next;
            sqi_reg    <= sqi_next;
            xp_reg     <= xp_next;
            xp_neg_reg <= neg_reg;
        end

        if (cmd.add)
        begin
            mr_reg  <= zr_mag[MAG_W-1:0];
            mi_reg  <= zi_mag[MAG_W-1:0];
            neg_reg <= zr[Z_W-1] ^ zi[Z_W-1];
        end
    end

    assign status.sum_esc = sq_sum[SQ_W];
    assign status.big     = big_reg;

endmodule

`default_nettype wire

/* rtl/mbet_ctrl.sv */
`default_nettype none

module mbet_ctrl (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    input  wire  mbet_pkg::mbet_status_t  status,
    output mbet_pkg::mbet_cmd_t           cmd,
    output logic                          busy,
    output logic                          done,
    output logic [mbet_pkg::OUT_W-1:0]    iteration_count
);
    import mbet_pkg::*;

    mbet_state_t      state_reg, state_next;
    logic [CNT_W-1:0] reps_reg, reps_next;
    logic             pending_reg, pending_next;
    logic             done_reg, done_next;
    logic [OUT_W-1:0] count_reg, count_next;

    logic [CNT_W-1:0] reps_eff;
    logic             sum_exit;
    logic             limit_exit;

    // An iteration counts as completed once its squares have passed the
    // sum test, which happens at the start of the following add step.
    always_comb
    begin
        reps_eff   = reps_reg + CNT_W'(pending_reg);
        sum_exit   = pending_reg && status.sum_esc;
        limit_exit = (reps_eff == CNT_W'(ITER_LIMIT));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (sum_exit || limit_exit)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (status.big)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_ADD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        reps_next    = reps_reg;
        pending_next = pending_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    reps_next    = '0;
                    pending_next = 1'b0;
                end
            end
            ST_ADD:
            begin
                if (sum_exit)
                begin
                    done_next  = 1'b1;
                    count_next = OUT_W'(reps_reg);
                end
                else if (limit_exit)
                begin
                    done_next  = 1'b1;
                    count_next = OUT_W'(reps_eff);
                end
                else
                begin
                    cmd.add      = 1'b1;
                    reps_next    = reps_eff;
                    pending_next = 1'b0;
                end
            end
            ST_SQUARE:
            begin
                if (status.big)
                begin
                    done_next  = 1'b1;
                    count_next = OUT_W'(reps_reg);
                end
                else
                begin
                    cmd.square   = 1'b1;
                    pending_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            reps_reg    <= '0;
            pending_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            reps_reg    <= reps_next;
            pending_reg <= pending_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign iteration_count = count_reg;

endmodule

`default_nettype wire

/* rtl/mandelbrot_escape_time_top.sv */
`default_nettype none

// Mandelbrot escape-time counter for one point c per command.
//
// A command is a transfer at a rising clock edge at which start is high and
// busy is low; c_real and c_imag are signed Q4.28 values sampled at that edge.
// Starting from z = 0 the block repeats z = z*z + c and reports on
// iteration_count how many iterations completed before |z| reached 2, or the
// iteration limit (256) if it never did.
// Each iteration is an add step that forms z and its
// magnitudes, then a multiply step in which three 29 x 29 bit multipliers
// form zr^2, zi^2 and 2*zr*zi. That loop through the multipliers sets the
// rate; a point that reaches the limit is the longest case. One point
// occupies the block until its result is presented.
// The result is presented for exactly one cycle with done high; the receiver
// takes it in that cycle and cannot hold it off. busy falls in the same cycle,
// so the next command may be issued while done is still high.
// Reset, asynchronous and active low, returns the block to idle with no
// result pending; no item in flight at that moment is reported.

module mandelbrot_escape_time_top (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire  [mbet_pkg::C_W-1:0]    c_real,
    input  wire  [mbet_pkg::C_W-1:0]    c_imag,
    output logic                        done,
    output logic [mbet_pkg::OUT_W-1:0]  iteration_count
);
    import mbet_pkg::*;

    mbet_cmd_t    cmd;
    mbet_status_t status;

    // The sequencer owns the iteration count and the result strobe.
    mbet_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .status          (status),
        .cmd             (cmd),
        .busy            (busy),
        .done            (done),
        .iteration_count (iteration_count)
    );

    // The datapath holds c and the current squares and reports the escape
    // tests back to the sequencer.
    mbet_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .c_real (c_real),
        .c_imag (c_imag),
        .status (status)
    );

endmodule

`default_nettype wire
